// File: sv/set_assoc_lru_cache_tags_macros.svh
`ifndef SET_ASSOC_LRU_CACHE_TAGS_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define SALC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked while out of reset.
`define SALC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/salc_pkg.sv
`default_nettype none
package salc_pkg;

   localparam int MAX_SET_BITS = 6;
   localparam int NUM_WAYS     = 8;
   localparam int NUM_SETS     = 1 << MAX_SET_BITS;
   localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W        = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int WAY_CNT_W    = $clog2(NUM_WAYS + 1);

   localparam int ADDR_W    = 64;
   localparam int TAG_W     = 64;
   localparam int CNT_W     = 32;
   localparam int CMD_W     = 2;
   localparam int OUTCOME_W = 2;

   localparam int SIB_W      = 3;
   localparam int BOB_W      = 6;
   localparam int WIU_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_INDEX_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_OFFSET_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_IN_USE       = 2'd2;

   localparam logic [SIB_W-1:0] RST_SET_INDEX_BITS    = 3'd4;
   localparam logic [BOB_W-1:0] RST_BLOCK_OFFSET_BITS = 6'd4;
   localparam logic [WIU_W-1:0] RST_WAYS_IN_USE       = 4'd8;

   localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

   localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_FILL  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   typedef struct packed {
      logic accept;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [NUM_WAYS-1:0]             valid;
      logic [NUM_WAYS-1:0][WAY_W-1:0]  rank;
      logic [NUM_WAYS-1:0][TAG_W-1:0]  tag;
   } row_type;

endpackage
`default_nettype wire

// File: sv/salc_req_if.sv
`default_nettype none
interface salc_req_if import salc_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [ADDR_W-1:0] address;

   modport source (output valid, command, address, input ready);
   modport sink   (input valid, command, address, output ready);
endinterface
`default_nettype wire

// File: sv/salc_rsp_if.sv
`default_nettype none
interface salc_rsp_if import salc_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [OUTCOME_W-1:0] outcome;
   logic                 second_hit;
   logic [CNT_W-1:0]     hit_total;
   logic [CNT_W-1:0]     miss_total;
   logic [CNT_W-1:0]     eviction_total;

   modport source (output valid, outcome, second_hit, hit_total, miss_total,
                   eviction_total, input ready);
   modport sink   (input valid, outcome, second_hit, hit_total, miss_total,
                   eviction_total, output ready);
endinterface
`default_nettype wire

// File: sv/salc_ctrl.sv
`default_nettype none
module salc_ctrl import salc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  wire logic   rsp_ready,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // hold until the previous result is gone or leaves now
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// File: sv/salc_dpath.sv
`default_nettype none
module salc_dpath import salc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_cmd_type          cmd,
   input  wire logic [CMD_W-1:0]      req_command,
   input  wire logic [ADDR_W-1:0]     req_address,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [OUTCOME_W-1:0]       rsp_outcome,
   output logic                       rsp_second_hit,
   output logic [CNT_W-1:0]           rsp_hit_total,
   output logic [CNT_W-1:0]           rsp_miss_total,
   output logic [CNT_W-1:0]           rsp_eviction_total
);

   function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] v, logic [1:0] inc);
      logic [CNT_W:0] sum;
      sum = {1'b0, v} + (CNT_W+1)'(inc);
      return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
   endfunction

   // configuration
   logic [SIB_W-1:0] set_index_bits_ff;
   logic [BOB_W-1:0] block_offset_bits_ff;
   logic [WIU_W-1:0] ways_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_index_bits_ff    <= RST_SET_INDEX_BITS;
         block_offset_bits_ff <= RST_BLOCK_OFFSET_BITS;
         ways_in_use_ff       <= RST_WAYS_IN_USE;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SET_INDEX_BITS:    set_index_bits_ff    <= csr_wdata[SIB_W-1:0];
            CSR_BLOCK_OFFSET_BITS: block_offset_bits_ff <= csr_wdata[BOB_W-1:0];
            CSR_WAYS_IN_USE:       ways_in_use_ff       <= csr_wdata[WIU_W-1:0];
            default: ;
         endcase
      end
   end

   // address split
   logic [SIB_W-1:0]     set_bits_eff;
   logic [SIB_W+BOB_W-1:0] tag_shift;
   logic [ADDR_W-1:0]    set_mask;
   logic [ADDR_W-1:0]    set_full;
   logic [SET_W-1:0]     req_set;
   logic [TAG_W-1:0]     req_tag;
   logic [WAY_CNT_W-1:0] ways_eff;

   always_comb begin
      set_bits_eff = (32'(set_index_bits_ff) > MAX_SET_BITS) ? SIB_W'(MAX_SET_BITS)
                                                            : set_index_bits_ff;
      set_mask  = (ADDR_W'(1) << set_bits_eff) - ADDR_W'(1);
      set_full  = (req_address >> block_offset_bits_ff) & set_mask;
      req_set   = set_full[SET_W-1:0];
      tag_shift = (SIB_W+BOB_W)'(set_bits_eff) + (SIB_W+BOB_W)'(block_offset_bits_ff);
      // shifting the whole word out leaves a zero tag
      req_tag   = (tag_shift >= (SIB_W+BOB_W)'(ADDR_W)) ? '0
                                                        : TAG_W'(req_address >> tag_shift);
      if (ways_in_use_ff == '0) begin
         ways_eff = WAY_CNT_W'(1);
      end else if (32'(ways_in_use_ff) > NUM_WAYS) begin
         ways_eff = WAY_CNT_W'(NUM_WAYS);
      end else begin
         ways_eff = WAY_CNT_W'(ways_in_use_ff);
      end
   end

   // set memory and per-set initialized bits
   row_type             row_mem [NUM_SETS];
   row_type             rd_row_ff;
   logic [NUM_SETS-1:0] row_init_ff;
   logic [SET_W-1:0]    set_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic                modify_ff;
   row_type             new_row;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_row_ff <= row_mem[req_set];
         set_ff    <= req_set;
         tag_ff    <= req_tag;
         modify_ff <= (req_command == CMD_MODIFY);
      end
      if (cmd.commit) begin
         row_mem[set_ff] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_init_ff <= '0;
      end else if (cmd.commit) begin
         row_init_ff[set_ff] <= 1'b1;
      end
   end

   // lookup and update
   row_type              cur_row;
   logic [NUM_WAYS-1:0]  in_use;
   logic [NUM_WAYS-1:0]  hit_vec;
   logic [NUM_WAYS-1:0]  free_vec;
   logic [NUM_WAYS-1:0]  oldest_vec;
   logic [WAY_W-1:0]     hit_way;
   logic [WAY_W-1:0]     free_way;
   logic [WAY_W-1:0]     oldest_way;
   logic [WAY_W-1:0]     touch_way;
   logic [WAY_W-1:0]     touch_rank;
   logic                 is_hit;
   logic                 is_fill;
   logic [OUTCOME_W-1:0] outcome;

   always_comb begin
      cur_row = rd_row_ff;
      if (!row_init_ff[set_ff]) begin
         cur_row.valid = '0;
         for (int w = 0; w < NUM_WAYS; w++) begin
            cur_row.rank[w] = WAY_W'(w);
         end
      end

      for (int w = 0; w < NUM_WAYS; w++) begin
         in_use[w]   = WAY_CNT_W'(w) < ways_eff;
         hit_vec[w]  = in_use[w] && cur_row.valid[w] && (cur_row.tag[w] == tag_ff);
         free_vec[w] = in_use[w] && !cur_row.valid[w];
      end

      // ranks form a permutation, so exactly one in-use way is oldest
      for (int w = 0; w < NUM_WAYS; w++) begin
         oldest_vec[w] = in_use[w];
         for (int v = 0; v < NUM_WAYS; v++) begin
            if (in_use[v] && (cur_row.rank[v] > cur_row.rank[w])) begin
               oldest_vec[w] = 1'b0;
            end
         end
      end

      hit_way    = '0;
      free_way   = '0;
      oldest_way = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) hit_way = WAY_W'(w);
         if (free_vec[w]) free_way = WAY_W'(w);
         if (oldest_vec[w]) oldest_way = WAY_W'(w);
      end

      is_hit  = |hit_vec;
      is_fill = !is_hit && (|free_vec);
      if (is_hit) begin
         touch_way = hit_way;
         outcome   = OUTCOME_HIT;
      end else if (is_fill) begin
         touch_way = free_way;
         outcome   = OUTCOME_FILL;
      end else begin
         touch_way = oldest_way;
         outcome   = OUTCOME_EVICT;
      end

      // move the touched way to the front, age the ones that were newer
      touch_rank = cur_row.rank[touch_way];
      new_row    = cur_row;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (cur_row.rank[w] < touch_rank) begin
            new_row.rank[w] = cur_row.rank[w] + WAY_W'(1);
         end
      end
      new_row.rank[touch_way]  = '0;
      new_row.valid[touch_way] = 1'b1;
      if (!is_hit) begin
         new_row.tag[touch_way] = tag_ff;
      end
   end

   // totals; a modify's second access always hits the way just touched
   logic [CNT_W-1:0]     hit_cnt_ff, miss_cnt_ff, evict_cnt_ff;
   logic [OUTCOME_W-1:0] outcome_ff;
   logic                 second_hit_ff;
   logic [1:0]           hit_inc;

   assign hit_inc = {1'b0, is_hit} + {1'b0, modify_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
      end else if (cmd.commit) begin
         hit_cnt_ff   <= sat_add(hit_cnt_ff, hit_inc);
         miss_cnt_ff  <= sat_add(miss_cnt_ff, {1'b0, !is_hit});
         evict_cnt_ff <= sat_add(evict_cnt_ff, {1'b0, !is_hit && !is_fill});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         outcome_ff    <= outcome;
         second_hit_ff <= modify_ff;
      end
   end

   assign rsp_outcome        = outcome_ff;
   assign rsp_second_hit     = second_hit_ff;
   assign rsp_hit_total      = hit_cnt_ff;
   assign rsp_miss_total     = miss_cnt_ff;
   assign rsp_eviction_total = evict_cnt_ff;

endmodule
`default_nettype wire

// File: sv/set_assoc_lru_cache_tags.sv
// Tag store of a set-associative LRU cache with saturating hit, miss and
// eviction totals, one item in flight at a time. The set's row (tags, valid
// bits, recency ranks) is read from a single-port row memory into a register
// when the item is accepted; the lookup state then compares, picks the way,
// writes the row back and loads the result register. A modify's second
// access is resolved in that same pass. The result register frees the input
// side at once, but a second item's update waits while the previous result
// is still not taken. There is no clearing pass after reset: one flip-flop
// per set marks rows never written, which read as empty with ranks in way order.
`default_nettype none
`include "set_assoc_lru_cache_tags_macros.svh"
module set_assoc_lru_cache_tags import salc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   salc_req_if.sink                   req_chan,
   salc_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type cmd;
   logic         req_ready;
   logic         rsp_valid;

   salc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   salc_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_command        (req_chan.command),
      .req_address        (req_chan.address),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_outcome        (rsp_chan.outcome),
      .rsp_second_hit     (rsp_chan.second_hit),
      .rsp_hit_total      (rsp_chan.hit_total),
      .rsp_miss_total     (rsp_chan.miss_total),
      .rsp_eviction_total (rsp_chan.eviction_total)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   `SALC_ASSERT_NEXT(a_one_item_in_flight, clock, reset, req_chan.valid && req_ready, !req_ready && !cmd.accept, "item accepted while another is in flight")
   `SALC_ASSERT_NOW(a_commit_needs_room, clock, reset, cmd.commit, !rsp_valid || rsp_chan.ready, "result overwritten before it was taken")
   `SALC_ASSERT_NEXT(a_commit_shows_result, clock, reset, cmd.commit, rsp_valid, "committed item did not raise a result")
   `SALC_ASSERT_NOW(a_accept_not_commit, clock, reset, cmd.accept, !cmd.commit, "accept and commit in the same cycle")

endmodule
`default_nettype wire

// File: test/tb_set_assoc_lru_cache_tags.sv
`timescale 1ns / 100ps
module tb_set_assoc_lru_cache_tags;
   import salc_pkg::*;

   localparam logic [CMD_W-1:0]     CMD_LOAD        = 2'd0;
   localparam logic [CMD_W-1:0]     CMD_STORE       = 2'd1;
   localparam logic [CMD_W-1:0]     CMD_UNUSED      = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_SUCH_REG = 2'd3;

   localparam int MAX_WAIT       = 10;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 150;
   localparam int TAG_POOL_SIZE  = 16;

   typedef enum logic {OP_ACCESS, OP_CSR_WRITE} op_kind_type;

   typedef struct {
      op_kind_type            kind;
      logic [CMD_W-1:0]       command;
      logic [ADDR_W-1:0]      address;
      logic [CSR_IDX_W-1:0]   reg_index;
      logic [CSR_DATA_W-1:0]  reg_data;
   } cache_op_type;

   typedef struct {
      logic [OUTCOME_W-1:0] outcome;
      logic                 second_hit;
      logic [CNT_W-1:0]     hits;
      logic [CNT_W-1:0]     misses;
      logic [CNT_W-1:0]     evictions;
   } lookup_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   salc_req_if req_if ();
   salc_rsp_if rsp_if ();

   set_assoc_lru_cache_tags dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #2 clock = ~clock;

   // shadow of the tag store and its settings
   logic [TAG_W-1:0] tag_store   [NUM_SETS][NUM_WAYS];
   logic             valid_store [NUM_SETS][NUM_WAYS];
   logic [WAY_W-1:0] rank_store  [NUM_SETS][NUM_WAYS];
   logic [CNT_W-1:0] hit_count, miss_count, evict_count;
   logic [SIB_W-1:0] cfg_set_bits;
   logic [BOB_W-1:0] cfg_offset_bits;
   logic [WIU_W-1:0] cfg_ways;

   cache_op_type      op_queue [$];
   lookup_result_type expected_results [$];
   cache_op_type      offered_op;

   // settings as planned while the op queue is built
   int plan_sets, plan_offset, plan_ways;
   logic [TAG_W-1:0] tag_pool [TAG_POOL_SIZE];

   int  sent_count, checked_count, mismatch_count;
   int  gap_left, quiet_cycles, stall_left, idle_cycles;
   bit  source_calm, sink_calm;
   int  first_hits, fills, evictions_seen, modifies, reg_writes;
   logic offer, write_now, take;

   function automatic void promote_way(int set_no, int way);
      logic [WAY_W-1:0] old_rank;
      old_rank = rank_store[set_no][way];
      for (int w = 0; w < NUM_WAYS; w++)
         if (rank_store[set_no][w] < old_rank) rank_store[set_no][w]++;
      rank_store[set_no][way] = '0;
   endfunction

   function automatic logic [OUTCOME_W-1:0] access_line(logic [ADDR_W-1:0] addr);
      int s, b, e, set_no, victim, best;
      logic [TAG_W-1:0] line_id;
      s = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set_bits);
      b = int'(cfg_offset_bits);
      e = (cfg_ways == 0) ? 1 : ((cfg_ways > NUM_WAYS) ? NUM_WAYS : int'(cfg_ways));
      line_id = (s + b >= ADDR_W) ? '0 : addr >> (s + b);
      set_no = (b >= ADDR_W) ? 0 : int'((addr >> b) & ((64'd1 << s) - 64'd1));
      set_no = set_no & (NUM_SETS - 1);
      for (int w = 0; w < e; w++) begin
         if (valid_store[set_no][w] && tag_store[set_no][w] == line_id) begin
            if (hit_count != '1) hit_count++;
            promote_way(set_no, w);
            return OUTCOME_HIT;
         end
      end
      if (miss_count != '1) miss_count++;
      for (int w = 0; w < e; w++) begin
         if (!valid_store[set_no][w]) begin
            valid_store[set_no][w] = 1'b1;
            tag_store[set_no][w] = line_id;
            promote_way(set_no, w);
            return OUTCOME_FILL;
         end
      end
      if (evict_count != '1) evict_count++;
      victim = 0;
      best = -1;
      for (int w = 0; w < e; w++) begin
         if (int'(rank_store[set_no][w]) > best) begin
            best = int'(rank_store[set_no][w]);
            victim = w;
         end
      end
      tag_store[set_no][victim] = line_id;
      promote_way(set_no, victim);
      return OUTCOME_EVICT;
   endfunction

   task automatic predict_item(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
      lookup_result_type r;
      r.outcome = access_line(addr);
      r.second_hit = 1'b0;
      // a modify touches the line twice
      if (cmd == CMD_MODIFY) begin
         r.second_hit = (access_line(addr) == OUTCOME_HIT);
         modifies++;
      end
      r.hits = hit_count;
      r.misses = miss_count;
      r.evictions = evict_count;
      expected_results.push_back(r);
      case (r.outcome)
         OUTCOME_HIT: first_hits++;
         OUTCOME_FILL: fills++;
         default: evictions_seen++;
      endcase
   endtask

   task automatic note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: mismatch at result %0d: %s", $time, checked_count, what);
   endtask

   task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (want !== got) note_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
   endtask

   task automatic plan_access(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
      cache_op_type op;
      op.kind = OP_ACCESS;
      op.command = cmd;
      op.address = addr;
      op.reg_index = '0;
      op.reg_data = '0;
      op_queue.push_back(op);
   endtask

   task automatic plan_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      cache_op_type op;
      op.kind = OP_CSR_WRITE;
      op.command = CMD_LOAD;
      op.address = '0;
      op.reg_index = idx;
      op.reg_data = data;
      op_queue.push_back(op);
      case (idx)
         CSR_SET_INDEX_BITS:
            plan_sets = (data[SIB_W-1:0] > MAX_SET_BITS) ? MAX_SET_BITS : int'(data[SIB_W-1:0]);
         CSR_BLOCK_OFFSET_BITS: plan_offset = int'(data[BOB_W-1:0]);
         CSR_WAYS_IN_USE:
            plan_ways = (data[WIU_W-1:0] == 0) ? 1 :
                        ((data[WIU_W-1:0] > NUM_WAYS) ? NUM_WAYS : int'(data[WIU_W-1:0]));
         default: ;
      endcase
   endtask

   // reuse a few tags and sets so that hits and evictions are frequent
   function automatic logic [ADDR_W-1:0] pick_address();
      logic [ADDR_W-1:0] line_id, set_part, offset;
      line_id = tag_pool[$urandom_range(0, plan_ways + 2)];
      set_part = 64'($urandom_range(0, 3)) & ((64'd1 << plan_sets) - 64'd1);
      offset = {$urandom, $urandom} & ((64'd1 << plan_offset) - 64'd1);
      return (line_id << (plan_sets + plan_offset)) | (set_part << plan_offset) | offset;
   endfunction

   initial begin
      logic [SIB_W-1:0] sib;
      logic [BOB_W-1:0] bob;
      logic [WIU_W-1:0] wiu;
      req_if.valid = 1'b0;
      req_if.command = CMD_LOAD;
      req_if.address = '0;
      rsp_if.ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = CSR_SET_INDEX_BITS;
      csr_wdata = '0;

      for (int i = 0; i < NUM_SETS; i++)
         for (int w = 0; w < NUM_WAYS; w++) begin
            tag_store[i][w] = '0;
            valid_store[i][w] = 1'b0;
            rank_store[i][w] = WAY_W'(w);
         end
      hit_count = '0;
      miss_count = '0;
      evict_count = '0;
      cfg_set_bits = RST_SET_INDEX_BITS;
      cfg_offset_bits = RST_BLOCK_OFFSET_BITS;
      cfg_ways = RST_WAYS_IN_USE;
      plan_sets = int'(RST_SET_INDEX_BITS);
      plan_offset = int'(RST_BLOCK_OFFSET_BITS);
      plan_ways = int'(RST_WAYS_IN_USE);

      // directed: fill, hit, modify, unused command, address extremes
      plan_access(CMD_LOAD, 64'h0);
      plan_access(CMD_STORE, 64'h0);
      plan_access(CMD_MODIFY, 64'h10);
      plan_access(CMD_UNUSED, 64'h1F);
      plan_access(CMD_LOAD, '1);
      plan_access(CMD_STORE, 64'h8000_0000_0000_0000);
      // crowd set 0 until the least recent line goes
      for (int k = 1; k <= 8; k++) plan_access(CMD_LOAD, 64'(k) << 8);
      plan_access(CMD_LOAD, 64'h0);
      plan_access(CMD_MODIFY, 64'h100);
      // too many set bits, offset past the tag, no ways
      plan_csr(CSR_SET_INDEX_BITS, 6'h3F);
      plan_csr(CSR_BLOCK_OFFSET_BITS, 6'h3F);
      plan_csr(CSR_WAYS_IN_USE, 6'h30);
      plan_access(CMD_LOAD, 64'h0);
      plan_access(CMD_LOAD, 64'h8000_0000_0000_0000);
      plan_access(CMD_MODIFY, 64'h5);
      plan_csr(CSR_NO_SUCH_REG, 6'h2A);
      plan_csr(CSR_SET_INDEX_BITS, 6'h00);
      plan_csr(CSR_BLOCK_OFFSET_BITS, 6'h00);
      plan_csr(CSR_WAYS_IN_USE, 6'h0F);
      plan_access(CMD_LOAD, 64'h123);
      plan_access(CMD_MODIFY, 64'h123);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         sib = SIB_W'($urandom_range(0, 7));
         case ($urandom_range(0, 7))
            0: bob = '0;
            1: bob = '1;
            2: bob = BOB_W'($urandom_range(13, 62));
            default: bob = BOB_W'($urandom_range(1, 12));
         endcase
         wiu = WIU_W'($urandom_range(0, 15));
         plan_csr(CSR_SET_INDEX_BITS, {3'($urandom), sib});
         plan_csr(CSR_BLOCK_OFFSET_BITS, bob);
         plan_csr(CSR_WAYS_IN_USE, {2'($urandom), wiu});
         if ($urandom_range(0, 2) == 0) plan_csr(CSR_NO_SUCH_REG, 6'($urandom));
         for (int i = 0; i < TAG_POOL_SIZE; i++)
            tag_pool[i] = (i < 4) ? TAG_W'(i) : {$urandom, $urandom};
         for (int i = 0; i < PHASE_ITEMS; i++)
            plan_access(2'($urandom_range(0, 3)),
                        ($urandom_range(0, 6) == 0) ? {$urandom, $urandom} : pick_address());
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (op_queue.size() != 0 || req_if.valid || sent_count != checked_count)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_results.size() != 0)
         note_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      $display("ran %0d accesses (%0d modifies) across %0d register writes",
               sent_count, modifies, reg_writes);
      $display("first access: %0d hits, %0d fills, %0d evictions; %0d mismatches",
               first_hits, fills, evictions_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // request driver; register writes wait until every result is back
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         csr_write_en <= 1'b0;
         gap_left = 0;
         quiet_cycles = 0;
         sent_count = 0;
      end else begin
         offer = req_if.valid;
         write_now = 1'b0;
         if (req_if.valid && req_if.ready) begin
            predict_item(offered_op.command, offered_op.address);
            sent_count++;
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (op_queue.size() != 0) begin
               if (op_queue[0].kind == OP_ACCESS) begin
                  offered_op = op_queue.pop_front();
                  req_if.command <= offered_op.command;
                  req_if.address <= offered_op.address;
                  offer = 1'b1;
                  if ($urandom_range(0, 39) == 0) source_calm = !source_calm;
                  gap_left = source_calm ? 0 : $urandom_range(0, MAX_WAIT);
               end else if (sent_count == checked_count) begin
                  if (quiet_cycles < SETTLE_CYCLES) begin
                     quiet_cycles++;
                  end else begin
                     offered_op = op_queue.pop_front();
                     csr_index <= offered_op.reg_index;
                     csr_wdata <= offered_op.reg_data;
                     write_now = 1'b1;
                     quiet_cycles = 0;
                     reg_writes++;
                     case (offered_op.reg_index)
                        CSR_SET_INDEX_BITS: cfg_set_bits = offered_op.reg_data[SIB_W-1:0];
                        CSR_BLOCK_OFFSET_BITS: cfg_offset_bits = offered_op.reg_data[BOB_W-1:0];
                        CSR_WAYS_IN_USE: cfg_ways = offered_op.reg_data[WIU_W-1:0];
                        default: ;
                     endcase
                  end
               end
            end
         end
         req_if.valid <= offer;
         csr_write_en <= write_now;
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
         checked_count <= 0;
      end else begin
         take = rsp_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               note_mismatch("result with nothing outstanding");
            end else begin
               lookup_result_type want;
               want = expected_results.pop_front();
               check_field("outcome", CNT_W'(want.outcome), CNT_W'(rsp_if.outcome));
               check_field("second_hit", CNT_W'(want.second_hit), CNT_W'(rsp_if.second_hit));
               check_field("hit_total", want.hits, rsp_if.hit_total);
               check_field("miss_total", want.misses, rsp_if.miss_total);
               check_field("eviction_total", want.evictions, rsp_if.eviction_total);
               checked_count <= checked_count + 1;
            end
            if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
            stall_left = sink_calm ? 0 : $urandom_range(0, MAX_WAIT);
            take = (stall_left == 0);
         end else if (!take) begin
            if (stall_left > 0) stall_left--;
            take = (stall_left == 0);
         end
         rsp_if.ready <= take;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", idle_cycles);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
